// ===== rtl/stereo_fir_filter_assert.svh =====
// Assertion macros for the stereo FIR filter RTL.
// Included by modules that check their own control logic; no other dependencies.
// Define ASSERT_OFF to compile the checks out.
`ifndef STEREO_FIR_FILTER_ASSERT_SVH
`define STEREO_FIR_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SFIR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sfir assertion failed");
// next-cycle implication
`define SFIR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sfir assertion failed");
`else
`define SFIR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SFIR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/sfir_pkg.sv =====
// Shared types and constants for the stereo FIR filter.
// No dependencies; used by the interfaces, the cell, the MAC and the top level.
package sfir_pkg;

  localparam int DATA_W   = 32;
  localparam int MODE_W   = 2;
  localparam int IDX_W    = 7;
  localparam int TAPS_DEF = 65;

  typedef enum logic [MODE_W-1:0] {
    MODE_FILTER = 2'd0,
    MODE_COEF   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // one history entry: left sample low, right sample high
  typedef struct packed {
    logic signed [DATA_W-1:0] right;
    logic signed [DATA_W-1:0] left;
  } pair_t;

  // operation broadcast to every cell of the ring
  typedef struct packed {
    logic shift;
    logic rot;
    logic clr;
    logic cwr;
  } cell_ctl_t;

endpackage

// ===== rtl/sfir_in_if.sv =====
// Input channel of the stereo FIR filter: valid/ready plus one command item.
// Depends on sfir_pkg for field widths.
interface sfir_in_if;
  logic                                valid;
  logic                                ready;
  logic [sfir_pkg::MODE_W-1:0]         mode;
  logic signed [sfir_pkg::DATA_W-1:0]  left_in;
  logic signed [sfir_pkg::DATA_W-1:0]  right_in;
  logic [sfir_pkg::IDX_W-1:0]          tap_index;
  logic signed [sfir_pkg::DATA_W-1:0]  tap_value;

  modport source (output valid, mode, left_in, right_in, tap_index, tap_value,
                  input ready);
  modport sink (input valid, mode, left_in, right_in, tap_index, tap_value,
                output ready);
endinterface

// ===== rtl/sfir_out_if.sv =====
// Result channel of the stereo FIR filter: valid/ready plus one filtered pair.
// Depends on sfir_pkg for field widths.
interface sfir_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sfir_pkg::DATA_W-1:0]  left_out;
  logic signed [sfir_pkg::DATA_W-1:0]  right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

// ===== rtl/sfir_cell.sv =====
// One cell of the history/coefficient ring: holds one sample pair and one tap.
// Depends on sfir_pkg; instantiated TAPS times by stereo_fir_filter.
module sfir_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sfir_pkg::cell_ctl_t                ctl,
  input  logic                               sel,
  input  sfir_pkg::pair_t                    hist_prev,
  input  sfir_pkg::pair_t                    hist_next,
  input  logic signed [sfir_pkg::DATA_W-1:0] coef_next,
  input  logic signed [sfir_pkg::DATA_W-1:0] coef_wval,
  output sfir_pkg::pair_t                    hist,
  output logic signed [sfir_pkg::DATA_W-1:0] coef
);

  sfir_pkg::pair_t                    hist_r, hist_nxt;
  logic signed [sfir_pkg::DATA_W-1:0] coef_r, coef_nxt;

  always_comb begin
    hist_nxt = hist_r;
    if (ctl.clr) begin
      hist_nxt = '0;
    end else if (ctl.shift) begin
      hist_nxt = hist_prev;
    end else if (ctl.rot) begin
      hist_nxt = hist_next;
    end

    coef_nxt = coef_r;
    if (ctl.cwr && sel) begin
      coef_nxt = coef_wval;
    end else if (ctl.rot) begin
      coef_nxt = coef_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      coef_r <= '0;
    end else begin
      hist_r <= hist_nxt;
      coef_r <= coef_nxt;
    end
  end

  assign hist = hist_r;
  assign coef = coef_r;

endmodule

// ===== rtl/sfir_mac.sv =====
// Q31 multiply-accumulate for one channel: registered product, then floor
// shift and saturating add. Depends on sfir_pkg and the assertion header.
`include "stereo_fir_filter_assert.svh"

module sfir_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               clr,
  input  logic                               en,
  input  logic signed [sfir_pkg::DATA_W-1:0] x,
  input  logic signed [sfir_pkg::DATA_W-1:0] h,
  output logic signed [sfir_pkg::DATA_W-1:0] acc
);

  localparam int PW = 2 * sfir_pkg::DATA_W;
  localparam int QW = sfir_pkg::DATA_W + 1;
  localparam int SW = sfir_pkg::DATA_W + 2;

  logic signed [PW-1:0]                 prod_r, prod_nxt;
  logic                                 p_vld_r, p_vld_nxt;
  logic signed [sfir_pkg::DATA_W-1:0]   acc_r, acc_nxt;
  logic signed [PW-1:0]                 shifted;
  logic signed [QW-1:0]                 q;
  logic signed [SW-1:0]                 sum;

  always_comb begin
    prod_nxt  = PW'(x) * PW'(h);
    p_vld_nxt = en;
    // arithmetic shift floors; result fits in DATA_W+1 bits
    shifted   = prod_r >>> (sfir_pkg::DATA_W - 1);
    q         = shifted[QW-1:0];
    sum       = SW'(acc_r) + SW'(q);
    acc_nxt   = acc_r;
    if (clr) begin
      acc_nxt = '0;
    end else if (p_vld_r) begin
      if (sum[SW-1:sfir_pkg::DATA_W-1] == '0 || sum[SW-1:sfir_pkg::DATA_W-1] == '1) begin
        acc_nxt = sum[sfir_pkg::DATA_W-1:0];
      end else if (sum[SW-1]) begin
        acc_nxt = {1'b1, {(sfir_pkg::DATA_W-1){1'b0}}};
      end else begin
        acc_nxt = {1'b0, {(sfir_pkg::DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      p_vld_r <= p_vld_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign acc = acc_r;

  `SFIR_ASSERT_IMP(a_clr_no_pending, clk, rst_n, clr, !p_vld_r)
  `SFIR_ASSERT_IMP(a_clr_not_en, clk, rst_n, en, !clr)
  `SFIR_ASSERT_NXT(a_clr_zeroes, clk, rst_n, clr, acc_r == '0)

endmodule

// ===== rtl/stereo_fir_filter.sv =====
// Stereo FIR filter top level: ring of history/coefficient cells feeding one
// MAC per channel. Depends on sfir_pkg, sfir_in_if, sfir_out_if, sfir_cell, sfir_mac.
//
//   port     dir  handshake    contents
//   in_ch    in   valid/ready  mode, left_in, right_in, tap_index, tap_value
//   out_ch   out  valid/ready  left_out, right_out
//
// A filter item runs through the push edge, TAPS rotation steps of the
// cell ring (one tap per cycle through each channel's MAC), a drain state to retire
// the last product and a done state that loads the output register.
// Coefficient writes, history clears and unused modes leave the sequencer idle.
// Reset (rst_n low, synchronous) zeroes history, coefficients and the output valid.
// A full output register stalls the sequencer before the load; input is ready
// only while the sequencer is idle.
`include "stereo_fir_filter_assert.svh"

module stereo_fir_filter #(
  parameter int TAPS = sfir_pkg::TAPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sfir_in_if.sink    in_ch,
  sfir_out_if.source out_ch
);

  localparam int CW = $clog2(TAPS + 1);

  sfir_pkg::state_t                   state_r, state_nxt;
  logic [CW-1:0]                      cnt_r, cnt_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [sfir_pkg::DATA_W-1:0] out_left_r, out_right_r;
  logic                               accept, ld;
  logic                               in_run, run_last;
  logic                               is_filt, is_coef, is_clr;
  sfir_pkg::cell_ctl_t                ctl;
  sfir_pkg::pair_t                    new_pair;
  sfir_pkg::pair_t                    hist [TAPS];
  logic signed [sfir_pkg::DATA_W-1:0] coef [TAPS];
  logic [TAPS-1:0]                    sel;
  logic signed [sfir_pkg::DATA_W-1:0] sum_left, sum_right;

  assign in_ch.ready = (state_r == sfir_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_run      = (state_r == sfir_pkg::ST_RUN);
  assign run_last    = in_run && (cnt_r == CW'(TAPS - 1));

  always_comb begin
    is_filt = 1'b0;
    is_coef = 1'b0;
    is_clr  = 1'b0;
    unique case (sfir_pkg::mode_t'(in_ch.mode))
      sfir_pkg::MODE_FILTER: is_filt = 1'b1;
      sfir_pkg::MODE_COEF:   is_coef = 1'b1;
      sfir_pkg::MODE_CLEAR:  is_clr  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    ctl.shift = accept && is_filt;
    ctl.clr   = accept && is_clr;
    ctl.cwr   = accept && is_coef;
    ctl.rot   = in_run;
  end

  assign new_pair.left  = in_ch.left_in;
  assign new_pair.right = in_ch.right_in;

  // ring: shift toward the tail on a push, rotate toward the head while filtering
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    sfir_pkg::pair_t prev_pair;
    localparam int NXT = (i == TAPS - 1) ? 0 : i + 1;

    if (i == 0) begin : g_head
      assign prev_pair = new_pair;
    end else begin : g_body
      assign prev_pair = hist[i-1];
    end

    assign sel[i] = (32'(in_ch.tap_index) == 32'(i));

    sfir_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .sel       (sel[i]),
      .hist_prev (prev_pair),
      .hist_next (hist[NXT]),
      .coef_next (coef[NXT]),
      .coef_wval (in_ch.tap_value),
      .hist      (hist[i]),
      .coef      (coef[i])
    );
  end

  sfir_mac u_mac_l (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (ctl.shift),
    .en    (ctl.rot),
    .x     (hist[0].left),
    .h     (coef[0]),
    .acc   (sum_left)
  );

  sfir_mac u_mac_r (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (ctl.shift),
    .en    (ctl.rot),
    .x     (hist[0].right),
    .h     (coef[0]),
    .acc   (sum_right)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ld            = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      sfir_pkg::ST_IDLE: begin
        if (accept && is_filt) begin
          state_nxt = sfir_pkg::ST_RUN;
          cnt_nxt   = '0;
        end
      end
      sfir_pkg::ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (run_last) begin
          state_nxt = sfir_pkg::ST_DRAIN;
        end
      end
      sfir_pkg::ST_DRAIN: begin
        state_nxt = sfir_pkg::ST_DONE;
      end
      sfir_pkg::ST_DONE: begin
        // hold the sums until the output register frees up
        if (!out_valid_r || out_ch.ready) begin
          ld            = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sfir_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sfir_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfir_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_left_r  <= sum_left;
      out_right_r <= sum_right;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_left_r;
  assign out_ch.right_out = out_right_r;

  `SFIR_ASSERT_NXT(a_filt_starts, clk, rst_n, accept && is_filt, in_run && cnt_r == '0)
  `SFIR_ASSERT_IMP(a_drain_after_run, clk, rst_n, state_r == sfir_pkg::ST_DRAIN, $past(run_last))
  `SFIR_ASSERT_IMP(a_run_ring_only, clk, rst_n, in_run, !ctl.shift && !ctl.clr && !ctl.cwr)
  `SFIR_ASSERT_NXT(a_load_shows, clk, rst_n, ld, out_ch.valid && state_r == sfir_pkg::ST_IDLE)

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the stereo FIR filter: drives command items, predicts
// each filtered pair in SystemVerilog and checks every result as it leaves the block.
// Depends on sfir_pkg, sfir_in_if, sfir_out_if and stereo_fir_filter from rtl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = sfir_pkg::DATA_W;
  localparam int MODE_W = sfir_pkg::MODE_W;
  localparam int IDX_W  = sfir_pkg::IDX_W;
  localparam int TAPS = sfir_pkg::TAPS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = TAPS + 8;
  localparam int IDLE_PCT = 13;
  localparam int MAX_REPORTS = 100;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam longint Q31_MAX = 64'sd2147483647;
  localparam longint Q31_MIN = -64'sd2147483648;
  localparam logic signed [DATA_W-1:0] FULL_NEG = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] FULL_POS = 32'sh7fff_ffff;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
    logic [IDX_W-1:0]         tap;
    logic signed [DATA_W-1:0] value;
  } fir_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
  } stereo_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  sfir_in_if  in_ch();
  sfir_out_if out_ch();

  stereo_fir_filter #(.TAPS(TAPS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // filter state as the block should hold it
  logic signed [DATA_W-1:0] hist_left  [TAPS];
  logic signed [DATA_W-1:0] hist_right [TAPS];
  logic signed [DATA_W-1:0] coefs      [TAPS];
  int unsigned              push_pos;

  stereo_pair_t filtered_q[$];
  int  mismatches = 0;
  int  stall_cycles = 0;
  bit  steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= !take_break();
  end

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s mismatch: got %h, want %h", $realtime, field, got, want);
    mismatches++;
  endtask

  function automatic longint q31_mul(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return prod >>> 31;
  endfunction

  function automatic longint sat_accumulate(input longint acc, input longint term);
    longint sum;
    sum = acc + term;
    if (sum > Q31_MAX) return Q31_MAX;
    if (sum < Q31_MIN) return Q31_MIN;
    return sum;
  endfunction

  function automatic stereo_pair_t filter_pair(input logic signed [DATA_W-1:0] l,
                                               input logic signed [DATA_W-1:0] r);
    int unsigned  slot;
    int unsigned  k;
    longint       acc_l;
    longint       acc_r;
    stereo_pair_t y;
    slot = TAPS - 1 - push_pos;
    hist_left[slot]  = l;
    hist_right[slot] = r;
    acc_l = 0;
    acc_r = 0;
    for (int j = 0; j < TAPS; j++) begin
      k = (slot + j) % TAPS;
      acc_l = sat_accumulate(acc_l, q31_mul(hist_left[k], coefs[j]));
      acc_r = sat_accumulate(acc_r, q31_mul(hist_right[k], coefs[j]));
    end
    push_pos = (push_pos + 1) % TAPS;
    y.left  = acc_l[DATA_W-1:0];
    y.right = acc_r[DATA_W-1:0];
    return y;
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < TAPS; i++) begin
      hist_left[i]  = '0;
      hist_right[i] = '0;
    end
  endfunction

  function automatic void track_item(input fir_cmd_t c);
    case (c.mode)
      sfir_pkg::MODE_FILTER: filtered_q.push_back(filter_pair(c.left, c.right));
      sfir_pkg::MODE_COEF: begin
        if (c.tap < TAPS) coefs[c.tap] = c.value;
      end
      sfir_pkg::MODE_CLEAR: clear_history();
      default: ;
    endcase
  endfunction

  // every field random, so unused fields toggle too
  function automatic fir_cmd_t random_cmd(input logic [MODE_W-1:0] mode);
    fir_cmd_t c;
    c.mode  = mode;
    c.left  = $urandom;
    c.right = $urandom;
    c.tap   = IDX_W'($urandom);
    c.value = $urandom;
    return c;
  endfunction

  function automatic fir_cmd_t filter_cmd(input logic signed [DATA_W-1:0] l,
                                          input logic signed [DATA_W-1:0] r);
    fir_cmd_t c;
    c = random_cmd(sfir_pkg::MODE_FILTER);
    c.left  = l;
    c.right = r;
    return c;
  endfunction

  function automatic fir_cmd_t coef_cmd(input logic [IDX_W-1:0] tap,
                                        input logic signed [DATA_W-1:0] value);
    fir_cmd_t c;
    c = random_cmd(sfir_pkg::MODE_COEF);
    c.tap   = tap;
    c.value = value;
    return c;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_sample();
    case ($urandom_range(9))
      0: return FULL_NEG;
      1: return FULL_POS;
      2: return $signed($urandom) >>> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] random_coef(input int shift);
    case ($urandom_range(19))
      0: return FULL_NEG;
      1: return FULL_POS;
      2: return '0;
      default: return $signed($urandom) >>> shift;
    endcase
  endfunction

  task automatic send_item(input fir_cmd_t c);
    @(negedge clk);
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= c.mode;
    in_ch.left_in   <= c.left;
    in_ch.right_in  <= c.right;
    in_ch.tap_index <= c.tap;
    in_ch.tap_value <= c.value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_item(c);
  endtask

  // hold off the input until every pending result has come out
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    stereo_pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected result", out_ch.left_out, '0);
      end else begin
        want = filtered_q.pop_front();
        if (out_ch.left_out !== want.left)
          report_mismatch("left_out", out_ch.left_out, want.left);
        if (out_ch.right_out !== want.right)
          report_mismatch("right_out", out_ch.right_out, want.right);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("stereo_fir_filter test failed");
        $finish;
      end
    end
  end

  // all coefficients zero after reset: every sum is zero
  task automatic test_after_reset();
    send_item(filter_cmd(FULL_POS, FULL_POS));
    send_item(filter_cmd(FULL_NEG, FULL_NEG));
    send_item(filter_cmd(32'sd1, -32'sd1));
  endtask

  task automatic test_corner_cases();
    send_item(coef_cmd(7'd0, FULL_NEG));
    send_item(coef_cmd(7'(TAPS - 1), FULL_POS));
    // out-of-range taps and the unused mode must leave the state alone
    send_item(coef_cmd(7'(TAPS), 32'sh1234_5678));
    send_item(coef_cmd(7'h7f, FULL_NEG));
    send_item(random_cmd(MODE_UNUSED));
    // two full-scale negatives give +1.0, which must saturate
    send_item(filter_cmd(FULL_NEG, FULL_NEG));
    send_item(filter_cmd(FULL_POS, FULL_NEG));
    send_item(filter_cmd('0, '0));
    send_item(filter_cmd(-32'sd1, 32'sd1));
    send_item(random_cmd(sfir_pkg::MODE_CLEAR));
    send_item(filter_cmd(32'sd1, -32'sd1));
    send_item(coef_cmd(7'd32, -32'sd1));
    send_item(filter_cmd(FULL_POS, FULL_POS));
    send_item(random_cmd(sfir_pkg::MODE_CLEAR));
    send_item(filter_cmd(FULL_NEG, FULL_POS));
    send_item(coef_cmd(7'd1, 32'sd0));
    send_item(filter_cmd(32'sd3, -32'sd7));
  endtask

  task automatic test_coefficient_set(input int shift);
    for (int t = 0; t < TAPS; t++)
      send_item(coef_cmd(7'(t), random_coef(shift)));
  endtask

  // mostly filter pairs, with retuning, clears and ignored items mixed in
  task automatic test_random_stream(input int count, input int shift);
    int       sent;
    int       pick;
    fir_cmd_t c;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        c = filter_cmd(random_sample(), random_sample());
        sent++;
      end else if (pick < 90) begin
        c = coef_cmd(7'($urandom_range(TAPS - 1)), random_coef(shift));
        sent++;
      end else if (pick < 93) begin
        c = random_cmd(sfir_pkg::MODE_CLEAR);
        sent++;
      end else if (pick < 96) begin
        c = coef_cmd(7'($urandom_range(127, TAPS)), $urandom);
      end else begin
        c = random_cmd(MODE_UNUSED);
      end
      send_item(c);
    end
  endtask

  task automatic finish_run();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && filtered_q.size() == 0)
      $display("stereo_fir_filter test passed");
    else
      $display("stereo_fir_filter test failed");
    $finish;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = sfir_pkg::MODE_FILTER;
    in_ch.left_in   = '0;
    in_ch.right_in  = '0;
    in_ch.tap_index = '0;
    in_ch.tap_value = '0;
    push_pos        = 0;
    clear_history();
    for (int i = 0; i < TAPS; i++) coefs[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_corner_cases();
    wait_for_results();

    test_coefficient_set(8);
    test_random_stream(450, 8);
    wait_for_results();

    steady = 1'b1;
    test_coefficient_set(4);
    test_random_stream(400, 4);
    steady = 1'b0;
    wait_for_results();

    test_coefficient_set(0);
    test_random_stream(300, 0);
    wait_for_results();

    test_coefficient_set(12);
    test_random_stream(450, 2);
    finish_run();
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sfir_pkg.sv
rtl/sfir_in_if.sv
rtl/sfir_out_if.sv
rtl/sfir_cell.sv
rtl/sfir_mac.sv
rtl/stereo_fir_filter.sv
dv/testbench.sv
